### rtl/fbsq_pkg.sv
// Shared types, codes and sizes for the frame buffer slot queue.
package fbsq_pkg;

	// Slot numbering and counter widths.
	localparam int SLOT_W    = 3;
	localparam int MAX_SLOTS = 1 << SLOT_W;
	localparam int CNT_W     = SLOT_W + 1;
	localparam int QSIZE_W   = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 4;

	localparam logic [QSIZE_W-1:0] QSIZE_RESET = QSIZE_W'(3);

	// Request codes.
	localparam logic [2:0] REQ_DEQUEUE = 3'd0;
	localparam logic [2:0] REQ_ENQUEUE = 3'd1;
	localparam logic [2:0] REQ_ACQUIRE = 3'd2;
	localparam logic [2:0] REQ_RELEASE = 3'd3;
	localparam logic [2:0] REQ_FLUSH   = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// Where a slot currently lives.
	localparam logic [1:0] PLACE_NONE  = 2'd0;
	localparam logic [1:0] PLACE_FREE  = 2'd1;
	localparam logic [1:0] PLACE_DIRTY = 2'd2;
	localparam logic [1:0] PLACE_HELD  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODE   = CFG_IDX_W'(1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic drain;
		logic pop_order;
		logic push_held;
		logic capture;
	} fbsq_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic enq_ok;
		logic drain_hit;
	} fbsq_stat_t;

endpackage

### rtl/fbsq_ctrl.sv
// Controller state machine for the frame buffer slot queue.
module fbsq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  fbsq_pkg::fbsq_stat_t   stat,
	output fbsq_pkg::fbsq_cmd_t    cmd
);
	import fbsq_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a new result when empty or being emptied.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd.load      = in_valid && (state_q == S_IDLE);
		cmd.exec      = (state_q == S_EXEC);
		cmd.drain     = (state_q == S_DRAIN);
		cmd.pop_order = (state_q == S_DRAIN) && stat.enq_ok && stat.drain_hit;
		cmd.push_held = (state_q == S_DRAIN) && stat.enq_ok && !stat.drain_hit;
		cmd.capture   = (state_q == S_DONE) && out_free;
	end

	// State register and output beat tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					// Stay while ordered slots keep moving to the dirty queue.
					if (!cmd.pop_order) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/fbsq_datapath.sv
// Datapath of the frame buffer slot queue: slot places, the three FIFOs and results.
module fbsq_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fbsq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbsq_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic [2:0]                        req_type,
	input  logic [fbsq_pkg::SLOT_W-1:0]       slot,
	input  fbsq_pkg::fbsq_cmd_t               cmd,
	output fbsq_pkg::fbsq_stat_t              stat,
	output logic [1:0]                        status,
	output logic [fbsq_pkg::SLOT_W-1:0]       out_slot,
	output logic                              newly_attached,
	output logic                              can_dequeue,
	output logic                              can_acquire,
	output logic                              acquirable_event,
	output logic                              dequeuable_event,
	output logic                              reset_event
);
	import fbsq_pkg::*;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SLOTS);

	// Configuration.
	logic [QSIZE_W-1:0] slot_limit_q;
	logic               seq_mode_q;

	// Slot bookkeeping.
	logic [1:0]        place_q [MAX_SLOTS];
	logic              mark_q  [MAX_SLOTS];
	logic [CNT_W-1:0]  attached_q;

	// FIFO storage and pointers.
	logic [SLOT_W-1:0] free_mem  [MAX_SLOTS];
	logic [SLOT_W-1:0] dirty_mem [MAX_SLOTS];
	logic [SLOT_W-1:0] order_mem [MAX_SLOTS];
	logic [SLOT_W-1:0] free_head_q, dirty_head_q, order_head_q;
	logic [CNT_W-1:0]  free_count_q, dirty_count_q, order_count_q;

	// Current request and per-request flags.
	logic [2:0]        req_q;
	logic [SLOT_W-1:0] slot_q;
	logic              mark_s_q;
	logic              enq_ok_q, rel_ok_q, rst_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] oslot_q;
	logic              fresh_q;

	// Output register.
	logic [1:0]        status_out_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              fresh_out_q, can_deq_out_q, can_acq_out_q;
	logic              acq_ev_out_q, deq_ev_out_q, rst_ev_out_q;

	// Combinational helpers.
	logic [SLOT_W-1:0] rd_addr;
	logic [1:0]        place_rd;
	logic              mark_rd;
	logic [CNT_W-1:0]  limit;
	logic              attach_ok;
	logic              slot_ok;
	logic [SLOT_W-1:0] free_tail, dirty_tail, order_tail, order_front;
	logic              deq_fresh, deq_ok;
	logic [SLOT_W-1:0] deq_slot;
	logic              enq_valid, acq_ok, rel_valid;
	logic              order_push, free_push_ok, dirty_push_ok;

	// Single read port on the slot tables: request slot, or order head while draining.
	always_comb begin
		order_front   = order_mem[order_head_q];
		rd_addr       = cmd.drain ? order_front : slot_q;
		place_rd      = place_q[rd_addr];
		mark_rd       = mark_q[rd_addr];
		limit         = (CNT_W'(slot_limit_q) > CNT_FULL) ? CNT_FULL : CNT_W'(slot_limit_q);
		attach_ok     = attached_q < limit;
		slot_ok       = CNT_W'(slot_q) < CNT_FULL;
		free_tail     = free_head_q + free_count_q[SLOT_W-1:0];
		dirty_tail    = dirty_head_q + dirty_count_q[SLOT_W-1:0];
		order_tail    = order_head_q + order_count_q[SLOT_W-1:0];
		free_push_ok  = free_count_q < CNT_FULL;
		dirty_push_ok = dirty_count_q < CNT_FULL;
		deq_fresh     = (free_count_q == '0) && attach_ok;
		deq_ok        = (free_count_q != '0) || attach_ok;
		deq_slot      = deq_fresh ? attached_q[SLOT_W-1:0] : free_mem[free_head_q];
		order_push    = deq_ok && seq_mode_q && (order_count_q < CNT_FULL);
		enq_valid     = slot_ok && (place_rd == PLACE_HELD);
		acq_ok        = dirty_count_q != '0;
		rel_valid     = slot_ok && (place_rd == PLACE_HELD) && !mark_rd;
	end

	assign stat.enq_ok    = enq_ok_q;
	assign stat.drain_hit = (order_count_q != '0) && (place_rd == PLACE_DIRTY);

	// Control state: configuration, slot places, marks, pointers and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q  <= QSIZE_RESET;
			seq_mode_q    <= 1'b0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				place_q[i] <= PLACE_NONE;
				mark_q[i]  <= 1'b0;
			end
			attached_q    <= '0;
			free_head_q   <= '0;
			dirty_head_q  <= '0;
			order_head_q  <= '0;
			free_count_q  <= '0;
			dirty_count_q <= '0;
			order_count_q <= '0;
			enq_ok_q      <= 1'b0;
			rel_ok_q      <= 1'b0;
			rst_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SLOT_LIMIT) begin
					slot_limit_q <= cfg_data[QSIZE_W-1:0];
				end else if (cfg_index == CFG_SEQ_MODE) begin
					seq_mode_q <= cfg_data[0];
				end
			end
			if (cmd.load) begin
				enq_ok_q <= 1'b0;
				rel_ok_q <= 1'b0;
				rst_q    <= 1'b0;
			end
			if (cmd.exec) begin
				unique case (req_q)
					REQ_DEQUEUE: begin
						if (deq_ok) begin
							place_q[deq_slot] <= PLACE_HELD;
							if (deq_fresh) begin
								attached_q <= attached_q + CNT_W'(1);
							end else begin
								free_head_q  <= free_head_q + SLOT_W'(1);
								free_count_q <= free_count_q - CNT_W'(1);
							end
							if (seq_mode_q) begin
								mark_q[deq_slot] <= 1'b1;
							end
							if (order_push) begin
								order_count_q <= order_count_q + CNT_W'(1);
							end
						end
					end
					REQ_ENQUEUE: begin
						if (enq_valid) begin
							place_q[slot_q] <= PLACE_DIRTY;
							enq_ok_q        <= 1'b1;
						end
					end
					REQ_ACQUIRE: begin
						if (acq_ok) begin
							place_q[dirty_mem[dirty_head_q]] <= PLACE_HELD;
							dirty_head_q  <= dirty_head_q + SLOT_W'(1);
							dirty_count_q <= dirty_count_q - CNT_W'(1);
						end
					end
					REQ_RELEASE: begin
						if (rel_valid) begin
							place_q[slot_q] <= PLACE_FREE;
							rel_ok_q        <= 1'b1;
							if (free_push_ok) begin
								free_count_q <= free_count_q + CNT_W'(1);
							end
						end
					end
					REQ_FLUSH: begin
						for (int i = 0; i < MAX_SLOTS; i++) begin
							place_q[i] <= PLACE_NONE;
							mark_q[i]  <= 1'b0;
						end
						attached_q    <= '0;
						free_head_q   <= '0;
						dirty_head_q  <= '0;
						order_head_q  <= '0;
						free_count_q  <= '0;
						dirty_count_q <= '0;
						order_count_q <= '0;
						rst_q         <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			// One ordered slot per cycle moves from the order queue to the dirty queue.
			if (cmd.pop_order) begin
				mark_q[order_front] <= 1'b0;
				order_head_q        <= order_head_q + SLOT_W'(1);
				order_count_q       <= order_count_q - CNT_W'(1);
				if (dirty_push_ok) begin
					dirty_count_q <= dirty_count_q + CNT_W'(1);
				end
			end
			// An enqueued slot that was never ordered joins the dirty tail last.
			if (cmd.push_held && !mark_s_q && dirty_push_ok) begin
				dirty_count_q <= dirty_count_q + CNT_W'(1);
			end
		end
	end

	// Payload: FIFO contents, request capture and per-request results.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			slot_q   <= slot;
			status_q <= ST_OK;
			oslot_q  <= '0;
			fresh_q  <= 1'b0;
			mark_s_q <= 1'b0;
		end
		if (cmd.exec) begin
			unique case (req_q)
				REQ_DEQUEUE: begin
					if (deq_ok) begin
						oslot_q <= deq_slot;
						fresh_q <= deq_fresh;
						if (order_push) begin
							order_mem[order_tail] <= deq_slot;
						end
					end else begin
						status_q <= ST_EMPTY;
					end
				end
				REQ_ENQUEUE: begin
					mark_s_q <= mark_rd;
					if (!enq_valid) begin
						status_q <= ST_INVALID;
					end
				end
				REQ_ACQUIRE: begin
					if (acq_ok) begin
						oslot_q <= dirty_mem[dirty_head_q];
					end else begin
						status_q <= ST_EMPTY;
					end
				end
				REQ_RELEASE: begin
					if (!rel_valid) begin
						status_q <= ST_INVALID;
					end else if (free_push_ok) begin
						free_mem[free_tail] <= slot_q;
					end
				end
				REQ_FLUSH: begin
				end
				default: begin
					status_q <= ST_INVALID;
				end
			endcase
		end
		if (cmd.pop_order && dirty_push_ok) begin
			dirty_mem[dirty_tail] <= order_front;
		end
		if (cmd.push_held && !mark_s_q && dirty_push_ok) begin
			dirty_mem[dirty_tail] <= slot_q;
		end
		// Result beat, built from the state left after the request.
		if (cmd.capture) begin
			status_out_q  <= status_q;
			out_slot_q    <= oslot_q;
			fresh_out_q   <= fresh_q;
			can_deq_out_q <= (free_count_q != '0) || attach_ok;
			can_acq_out_q <= dirty_count_q != '0;
			acq_ev_out_q  <= enq_ok_q && (dirty_count_q != '0);
			deq_ev_out_q  <= rel_ok_q && (free_count_q != '0);
			rst_ev_out_q  <= rst_q;
		end
	end

	assign status           = status_out_q;
	assign out_slot         = out_slot_q;
	assign newly_attached   = fresh_out_q;
	assign can_dequeue      = can_deq_out_q;
	assign can_acquire      = can_acq_out_q;
	assign acquirable_event = acq_ev_out_q;
	assign dequeuable_event = deq_ev_out_q;
	assign reset_event      = rst_ev_out_q;

endmodule

### rtl/frame_buffer_slot_queue.sv
// Top level of the frame buffer slot queue: controller plus datapath.
// Sequencing: a request beat is accepted, executed, then drained of ordered slots (an
// enqueue moves each ordered slot into the dirty queue, up to 8), and its result beat is captured.
// A new request is taken only once the controller has walked accept, execute, order drain
// and result capture for the last one; a stalled result holds the next request.
// Reset: arst_n clears every slot to unattached and empties all queues at once, with
// the slot limit at 3 and sequence_mode at 0; no clearing pass is needed.
module frame_buffer_slot_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fbsq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbsq_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        req_type,
	input  logic [fbsq_pkg::SLOT_W-1:0]       slot,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [fbsq_pkg::SLOT_W-1:0]       out_slot,
	output logic                              newly_attached,
	output logic                              can_dequeue,
	output logic                              can_acquire,
	output logic                              acquirable_event,
	output logic                              dequeuable_event,
	output logic                              reset_event
);
	import fbsq_pkg::*;

	fbsq_cmd_t  cmd;
	fbsq_stat_t stat;

	// Sequencing of each request.
	fbsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Slot state, queues and result register.
	fbsq_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_type         (req_type),
		.slot             (slot),
		.cmd              (cmd),
		.stat             (stat),
		.status           (status),
		.out_slot         (out_slot),
		.newly_attached   (newly_attached),
		.can_dequeue      (can_dequeue),
		.can_acquire      (can_acquire),
		.acquirable_event (acquirable_event),
		.dequeuable_event (dequeuable_event),
		.reset_event      (reset_event)
	);

endmodule
